// ===== rtl/core/kfci_pkg.sv =====
package kfci_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int QUEUE_DEPTH = 2;
    localparam int CHANNELS    = 9;
    localparam int TIME_W      = 31;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic [2:0] CFG_LOOP_LENGTH = 3'd0;
    localparam logic [2:0] CFG_KEY_COUNT   = 3'd1;
    localparam logic [2:0] CFG_INTERP_MODE = 3'd2;
    localparam logic [2:0] CFG_ENV_ENABLE  = 3'd3;
    localparam logic [2:0] CFG_ALPHA_RATIO = 3'd4;

    localparam logic [15:0] RST_LOOP_LENGTH = 16'd1;
    localparam logic [8:0]  RST_KEY_COUNT   = 9'd2;
    localparam logic        RST_INTERP_MODE = 1'b1;
    localparam logic        RST_ENV_ENABLE  = 1'b0;
    localparam logic [8:0]  RST_ALPHA_RATIO = 9'd256;

    typedef struct packed {
        logic              cmd;
        logic [7:0]        entry_index;
        logic [TIME_W-1:0] time_value;
        logic [7:0]        prim_red;
        logic [7:0]        prim_green;
        logic [7:0]        prim_blue;
        logic [7:0]        prim_alpha;
        logic [7:0]        prim_lod;
        logic [7:0]        env_red;
        logic [7:0]        env_green;
        logic [7:0]        env_blue;
        logic [7:0]        env_alpha;
    } req_t;

    typedef struct packed {
        logic [7:0] out_prim_red;
        logic [7:0] out_prim_green;
        logic [7:0] out_prim_blue;
        logic [7:0] out_prim_alpha;
        logic [7:0] out_prim_lod;
        logic [7:0] out_env_red;
        logic [7:0] out_env_green;
        logic [7:0] out_env_blue;
        logic [7:0] out_env_alpha;
        logic       env_valid;
        logic       index_error;
    } rsp_t;

    typedef struct packed {
        logic [15:0] loop_length;
        logic [8:0]  key_count;
        logic        interp_mode;
        logic        env_enable;
        logic [8:0]  alpha_ratio;
    } cfg_t;

    // Channel k of colors sits at bits [8k+7:8k]: prim red, green, blue,
    // alpha, lod, then env red, green, blue, alpha.
    typedef struct packed {
        logic                  cmd;
        logic [7:0]            entry_index;
        logic [15:0]           time_key;
        logic [8*CHANNELS-1:0] colors;
    } qent_t;

endpackage

// ===== rtl/core/kfci_ram.sv =====
module kfci_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/kfci_fifo.sv =====
module kfci_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    output logic            push_ready,
    input  kfci_pkg::qent_t push_data,
    output logic            pop_valid,
    input  logic            pop,
    output kfci_pkg::qent_t pop_data
);

    localparam int PW = (kfci_pkg::QUEUE_DEPTH > 1) ? $clog2(kfci_pkg::QUEUE_DEPTH) : 1;
    localparam int NW = $clog2(kfci_pkg::QUEUE_DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(kfci_pkg::QUEUE_DEPTH - 1);

    kfci_pkg::qent_t slot_reg [kfci_pkg::QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0] fill_reg, fill_next;
    logic          do_push;
    logic          do_pop;

    assign push_ready = (fill_reg != NW'(kfci_pkg::QUEUE_DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + NW'(1);
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - NW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== rtl/core/kfci_front.sv =====
module kfci_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_stall,
    input  kfci_pkg::req_t  req,
    input  logic [15:0]     loop_length,
    output logic            push_valid,
    input  logic            push_ready,
    output kfci_pkg::qent_t push_data
);

    localparam logic [4:0] DIV_LAST = 5'(kfci_pkg::TIME_W - 1);

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_DIV  = 3'b010,
        F_PUSH = 3'b100
    } fstate_t;

    fstate_t         state_reg, state_next;
    kfci_pkg::qent_t ent_reg, ent_next;
    logic [kfci_pkg::TIME_W-1:0] dvd_reg, dvd_next;
    logic [15:0]     rem_reg, rem_next;
    logic [15:0]     len_reg, len_next;
    logic [4:0]      bit_reg, bit_next;
    logic [16:0]     trial;

    always_comb
    begin
        state_next = state_reg;
        ent_next   = ent_reg;
        dvd_next   = dvd_reg;
        rem_next   = rem_reg;
        len_next   = len_reg;
        bit_next   = bit_reg;
        trial      = {rem_reg, dvd_reg[kfci_pkg::TIME_W-1]};
        case (state_reg)
            F_IDLE:
            begin
                if (req_valid)
                begin
                    ent_next.cmd         = req.cmd;
                    ent_next.entry_index = req.entry_index;
                    ent_next.time_key    = req.time_value[15:0];
                    ent_next.colors      = {req.env_alpha, req.env_blue, req.env_green,
                                            req.env_red, req.prim_lod, req.prim_alpha,
                                            req.prim_blue, req.prim_green, req.prim_red};
                    if (req.cmd == kfci_pkg::CMD_QUERY)
                    begin
                        dvd_next   = req.time_value;
                        rem_next   = '0;
                        len_next   = (loop_length == 16'd0) ? 16'd1 : loop_length;
                        bit_next   = DIV_LAST;
                        state_next = F_DIV;
                    end
                    else
                    begin
                        state_next = F_PUSH;
                    end
                end
            end
            F_DIV:
            begin
                if (trial >= {1'b0, len_reg})
                begin
                    rem_next = 16'(trial - {1'b0, len_reg});
                end
                else
                begin
                    rem_next = trial[15:0];
                end
                dvd_next = {dvd_reg[kfci_pkg::TIME_W-2:0], 1'b0};
                bit_next = bit_reg - 5'd1;
                if (bit_reg == 5'd0)
                begin
                    ent_next.time_key = rem_next;
                    state_next        = F_PUSH;
                end
            end
            F_PUSH:
            begin
                if (push_ready)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    assign req_stall  = (state_reg != F_IDLE);
    assign push_valid = (state_reg == F_PUSH);
    assign push_data  = ent_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ent_reg <= ent_next;
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        len_reg <= len_next;
        bit_reg <= bit_next;
    end

endmodule

// ===== rtl/core/kfci_back.sv =====
module kfci_back #(
    parameter int TABLE_DEPTH = kfci_pkg::TABLE_DEPTH
) (
    input  logic            clk,
    input  logic            rst_n,
    input  kfci_pkg::cfg_t  cfg,
    input  logic            q_valid,
    output logic            q_pop,
    input  kfci_pkg::qent_t q_data,
    output logic            rsp_valid,
    input  logic            rsp_stall,
    output kfci_pkg::rsp_t  rsp
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = ($clog2(TABLE_DEPTH + 1) > 9) ? $clog2(TABLE_DEPTH + 1) : 9;
    localparam int CH = kfci_pkg::CHANNELS;
    localparam int CB = 8 * CH;
    localparam int EW = 16 + CB;
    localparam logic [4:0] DIV_LAST = 5'd23;

    typedef enum logic [10:0] {
        B_IDLE   = 11'b000_0000_0001,
        B_STEP_W = 11'b000_0000_0010,
        B_SRCH   = 11'b000_0000_0100,
        B_SRCH_W = 11'b000_0000_1000,
        B_PAIR   = 11'b000_0001_0000,
        B_LO     = 11'b000_0010_0000,
        B_HI     = 11'b000_0100_0000,
        B_MUL    = 11'b000_1000_0000,
        B_ABS    = 11'b001_0000_0000,
        B_DIV    = 11'b010_0000_0000,
        B_OUT    = 11'b100_0000_0000
    } bstate_t;

    bstate_t               state_reg, state_next;
    logic                  rsp_valid_reg, rsp_valid_next;
    kfci_pkg::rsp_t        rsp_reg, rsp_next;
    logic [15:0]           frame_reg, frame_next;
    logic [CW-1:0]         idx_reg, idx_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic [15:0]           lo_t_reg, lo_t_next;
    logic [CB-1:0]         lo_c_reg, lo_c_next;
    logic [CB-1:0]         hi_c_reg, hi_c_next;
    logic signed [16:0]    span_reg, span_next;
    logic signed [16:0]    rel_reg, rel_next;
    logic signed [25:0]    prod_reg [CH];
    logic signed [25:0]    prod_next [CH];
    logic [23:0]           num_reg [CH];
    logic [23:0]           num_next [CH];
    logic [15:0]           rem_reg [CH];
    logic [15:0]           rem_next [CH];
    logic [7:0]            quo_reg [CH];
    logic [7:0]            quo_next [CH];
    logic [CH-1:0]         neg_reg, neg_next;
    logic [15:0]           dvs_reg, dvs_next;
    logic [4:0]            dcnt_reg, dcnt_next;
    logic [CB-1:0]         res_reg, res_next;
    logic                  err_reg, err_next;

    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [EW-1:0]         ram_wdata;
    logic [AW-1:0]         ram_raddr;
    logic [EW-1:0]         ram_rdata;
    logic [15:0]           rd_time;
    logic [CB-1:0]         rd_col;

    kfci_ram #(
        .WIDTH(EW),
        .DEPTH(TABLE_DEPTH)
    ) u_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign rd_time   = ram_rdata[EW-1:CB];
    assign rd_col    = ram_rdata[CB-1:0];
    assign ram_waddr = AW'(q_data.entry_index);
    assign ram_wdata = {q_data.time_key, q_data.colors};

    always_comb
    begin
        logic [CW-1:0]      idx_c;
        logic signed [8:0]  diff;
        logic signed [25:0] mag;
        logic [16:0]        dtrial;
        logic [7:0]         qv;
        logic [16:0]        ascaled;

        state_next     = state_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;
        frame_next     = frame_reg;
        idx_next       = idx_reg;
        cnt_next       = cnt_reg;
        lo_t_next      = lo_t_reg;
        lo_c_next      = lo_c_reg;
        hi_c_next      = hi_c_reg;
        span_next      = span_reg;
        rel_next       = rel_reg;
        prod_next      = prod_reg;
        num_next       = num_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        neg_next       = neg_reg;
        dvs_next       = dvs_reg;
        dcnt_next      = dcnt_reg;
        res_next       = res_reg;
        err_next       = err_reg;
        q_pop          = 1'b0;
        ram_we         = 1'b0;
        ram_raddr      = '0;
        idx_c          = idx_reg;
        diff           = '0;
        mag            = '0;
        dtrial         = '0;
        qv             = '0;
        ascaled        = '0;

        case (state_reg)
            B_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    if (q_data.cmd == kfci_pkg::CMD_LOAD)
                    begin
                        ram_we = (32'(q_data.entry_index) < TABLE_DEPTH);
                    end
                    else
                    begin
                        frame_next = q_data.time_key;
                        if (!cfg.interp_mode)
                        begin
                            if (32'(q_data.time_key) >= TABLE_DEPTH)
                            begin
                                res_next   = '0;
                                err_next   = 1'b1;
                                state_next = B_OUT;
                            end
                            else
                            begin
                                ram_raddr  = AW'(q_data.time_key);
                                state_next = B_STEP_W;
                            end
                        end
                        else
                        begin
                            cnt_next   = (CW'(cfg.key_count) > CW'(TABLE_DEPTH)) ?
                                         CW'(TABLE_DEPTH) : CW'(cfg.key_count);
                            idx_next   = CW'(1);
                            state_next = B_SRCH;
                        end
                    end
                end
            end
            B_STEP_W:
            begin
                res_next   = rd_col;
                err_next   = 1'b0;
                state_next = B_OUT;
            end
            B_SRCH:
            begin
                if (idx_reg < cnt_reg)
                begin
                    ram_raddr  = idx_reg[AW-1:0];
                    state_next = B_SRCH_W;
                end
                else
                begin
                    state_next = B_PAIR;
                end
            end
            B_SRCH_W:
            begin
                if (frame_reg >= rd_time)
                begin
                    idx_next   = idx_reg + CW'(1);
                    state_next = B_SRCH;
                end
                else
                begin
                    state_next = B_PAIR;
                end
            end
            B_PAIR:
            begin
                if (cnt_reg >= CW'(2) && idx_reg == cnt_reg)
                begin
                    idx_c = idx_reg - CW'(1);
                end
                ram_raddr  = AW'(idx_c - CW'(1));
                idx_next   = idx_c;
                state_next = B_LO;
            end
            B_LO:
            begin
                lo_t_next  = rd_time;
                lo_c_next  = rd_col;
                ram_raddr  = idx_reg[AW-1:0];
                state_next = B_HI;
            end
            B_HI:
            begin
                hi_c_next = rd_col;
                span_next = $signed({1'b0, rd_time}) - $signed({1'b0, lo_t_reg});
                rel_next  = $signed({1'b0, frame_reg}) - $signed({1'b0, lo_t_reg});
                if (rd_time == lo_t_reg)
                begin
                    res_next   = lo_c_reg;
                    err_next   = 1'b1;
                    state_next = B_OUT;
                end
                else
                begin
                    state_next = B_MUL;
                end
            end
            B_MUL:
            begin
                for (int k = 0; k < CH; k++)
                begin
                    diff = $signed({1'b0, hi_c_reg[8*k +: 8]})
                         - $signed({1'b0, lo_c_reg[8*k +: 8]});
                    prod_next[k] = 26'(diff) * 26'(rel_reg);
                end
                state_next = B_ABS;
            end
            B_ABS:
            begin
                for (int k = 0; k < CH; k++)
                begin
                    mag         = prod_reg[k][25] ? -prod_reg[k] : prod_reg[k];
                    num_next[k] = mag[23:0];
                    neg_next[k] = prod_reg[k][25] ^ span_reg[16];
                    rem_next[k] = '0;
                    quo_next[k] = '0;
                end
                dvs_next   = span_reg[16] ? 16'(-span_reg) : span_reg[15:0];
                dcnt_next  = DIV_LAST;
                state_next = B_DIV;
            end
            B_DIV:
            begin
                for (int k = 0; k < CH; k++)
                begin
                    dtrial = {rem_reg[k], num_reg[k][23]};
                    if (dtrial >= {1'b0, dvs_reg})
                    begin
                        rem_next[k] = 16'(dtrial - {1'b0, dvs_reg});
                        quo_next[k] = {quo_reg[k][6:0], 1'b1};
                    end
                    else
                    begin
                        rem_next[k] = dtrial[15:0];
                        quo_next[k] = {quo_reg[k][6:0], 1'b0};
                    end
                    num_next[k] = {num_reg[k][22:0], 1'b0};
                end
                dcnt_next = dcnt_reg - 5'd1;
                if (dcnt_reg == 5'd0)
                begin
                    for (int k = 0; k < CH; k++)
                    begin
                        qv = neg_reg[k] ? 8'(-quo_next[k]) : quo_next[k];
                        res_next[8*k +: 8] = lo_c_reg[8*k +: 8] + qv;
                    end
                    err_next   = 1'b0;
                    state_next = B_OUT;
                end
            end
            B_OUT:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    ascaled = 17'(res_reg[31:24]) * 17'(cfg.alpha_ratio);
                    rsp_next.out_prim_red   = res_reg[7:0];
                    rsp_next.out_prim_green = res_reg[15:8];
                    rsp_next.out_prim_blue  = res_reg[23:16];
                    rsp_next.out_prim_alpha = ascaled[16] ? 8'hFF : ascaled[15:8];
                    rsp_next.out_prim_lod   = res_reg[39:32];
                    rsp_next.out_env_red    = cfg.env_enable ? res_reg[47:40] : 8'd0;
                    rsp_next.out_env_green  = cfg.env_enable ? res_reg[55:48] : 8'd0;
                    rsp_next.out_env_blue   = cfg.env_enable ? res_reg[63:56] : 8'd0;
                    rsp_next.out_env_alpha  = cfg.env_enable ? res_reg[71:64] : 8'd0;
                    rsp_next.env_valid      = cfg.env_enable;
                    rsp_next.index_error    = err_reg;
                    rsp_valid_next          = 1'b1;
                    state_next              = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg   <= rsp_next;
        frame_reg <= frame_next;
        idx_reg   <= idx_next;
        cnt_reg   <= cnt_next;
        lo_t_reg  <= lo_t_next;
        lo_c_reg  <= lo_c_next;
        hi_c_reg  <= hi_c_next;
        span_reg  <= span_next;
        rel_reg   <= rel_next;
        prod_reg  <= prod_next;
        num_reg   <= num_next;
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
        neg_reg   <= neg_next;
        dvs_reg   <= dvs_next;
        dcnt_reg  <= dcnt_next;
        res_reg   <= res_next;
        err_reg   <= err_next;
    end

    a_pop_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid && state_reg == B_IDLE)
        else $error("queue popped without an entry");

    a_search_index: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_SRCH || state_reg == B_SRCH_W) |->
            idx_reg != '0 && (idx_reg <= cnt_reg || idx_reg == CW'(1)))
        else $error("search index out of range");

    a_pair_index: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == B_LO |-> idx_reg != '0 && idx_reg < CW'(TABLE_DEPTH))
        else $error("upper keyframe index outside the table");

    a_div_steps: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_DIV && dcnt_reg != 5'd0) |=>
            state_reg == B_DIV && dcnt_reg == $past(dcnt_reg) - 5'd1)
        else $error("divider left before its last step");

endmodule

// ===== rtl/core/keyframe_color_interpolator_top.sv =====
// A load is written into the table when the back part pops it from the queue, if its index lies
// within the table. In stepped mode a query reads the table entry for its frame, or flags an
// index error without a read for a frame beyond the table; in interpolating mode it searches the
// keyframes, then divides, unless the span is zero. The front part takes no new request until it
// has queued the last, which for a query means after its bit-serial modulo; the back part takes no
// new entry until it is done with the last, such as its search and 24-step division for a query.
// Reset clears control state and sets the registers to their reset values; the table holds no
// defined contents until loaded, and there is no clearing pass.
module keyframe_color_interpolator_top #(
    parameter int TABLE_DEPTH = kfci_pkg::TABLE_DEPTH
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  kfci_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output kfci_pkg::rsp_t rsp,
    input  logic           cfg_valid,
    output logic           cfg_ready,
    input  logic [2:0]     cfg_index,
    input  logic [15:0]    cfg_data
);

    kfci_pkg::cfg_t  cfg_reg, cfg_next;
    logic            push_valid;
    logic            push_ready;
    kfci_pkg::qent_t push_data;
    logic            q_valid;
    logic            q_pop;
    kfci_pkg::qent_t q_data;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                kfci_pkg::CFG_LOOP_LENGTH: cfg_next.loop_length = cfg_data;
                kfci_pkg::CFG_KEY_COUNT:   cfg_next.key_count   = cfg_data[8:0];
                kfci_pkg::CFG_INTERP_MODE: cfg_next.interp_mode = cfg_data[0];
                kfci_pkg::CFG_ENV_ENABLE:  cfg_next.env_enable  = cfg_data[0];
                kfci_pkg::CFG_ALPHA_RATIO: cfg_next.alpha_ratio = cfg_data[8:0];
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.loop_length <= kfci_pkg::RST_LOOP_LENGTH;
            cfg_reg.key_count   <= kfci_pkg::RST_KEY_COUNT;
            cfg_reg.interp_mode <= kfci_pkg::RST_INTERP_MODE;
            cfg_reg.env_enable  <= kfci_pkg::RST_ENV_ENABLE;
            cfg_reg.alpha_ratio <= kfci_pkg::RST_ALPHA_RATIO;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    kfci_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req        (req),
        .loop_length(cfg_reg.loop_length),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    kfci_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_valid(push_valid),
        .push_ready(push_ready),
        .push_data (push_data),
        .pop_valid (q_valid),
        .pop       (q_pop),
        .pop_data  (q_data)
    );

    kfci_back #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_data   (q_data),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp      (rsp)
    );

endmodule
